// ===== design/banded_pair_rle_decoder_top_defines.svh =====
// Assertion helpers for the banded pair RLE decoder.
`ifndef BANDED_PAIR_RLE_DECODER_TOP_DEFINES_SVH
`define BANDED_PAIR_RLE_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BPRD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bprd assertion failed");
`define BPRD_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("bprd assertion failed");
`else
`define BPRD_ASSERT(label, clk, rst, prop)
`define BPRD_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== design/bprd_pkg.sv =====
package bprd_pkg;

   typedef enum logic [2:0] {
      PH_BAND_START = 3'd0,
      PH_LITERAL    = 3'd1,
      PH_COUNT1     = 3'd2,
      PH_COUNT2     = 3'd3,
      PH_AFTER_RUN  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BEYOND    = 2'd1,
      ST_EARLY_END = 2'd2
   } status_type;

   localparam logic REG_OUTPUT_SIZE = 1'b0;
   localparam logic REG_BAND_COUNT  = 1'b1;

   localparam int unsigned SIZE_W  = 25;
   localparam int unsigned INDEX_W = 24;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned DIV_STEPS = 25;

   localparam logic [7:0]       LONG_COUNT_BIT = 8'h80;
   localparam logic [LEN_W-1:0] LONG_COUNT_BIAS = 16'h0080;

endpackage

// ===== design/banded_pair_rle_decoder_top.sv =====
// Banded pair RLE decoder.
// Input channel req_*: one compressed byte per transfer, req_stream_end marks
// the last byte. Result channel rsp_*: one strided run descriptor (or a
// status-only descriptor) per transfer; at most one result per input byte.
// Configuration over the APB-style port: output_size at 0x0, band_count at 0x4.
// Every write to either register starts a restoring division, by the band
// count, of the output bytes from the current band's first position on;
// quotient and remainder give the band's length and step down as bands
// advance. req_ready stays low while the division is pending or running.
// Throughput: one byte per cycle while no division runs and results are
// taken. The input byte is decoded when the result register is free or taken.
// An input register and a result register separate the two sides, so a byte
// is taken while a finished result waits; when rsp_ready stays low the
// input register fills and req_ready drops until the result is taken.
// After reset no division runs (size 0, one band) and decoding starts at
// band 0. Once the image is done or decoding failed, further bytes are
// consumed without results until the next reset.
`include "banded_pair_rle_decoder_top_defines.svh"

module banded_pair_rle_decoder_top
   import bprd_pkg::*;
#(
   parameter longint unsigned MAX_OUTPUT_SIZE = 16777216
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_stream_end,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [INDEX_W-1:0] rsp_out_index,
   output logic [7:0]         rsp_out_value,
   output logic [LEN_W-1:0]   rsp_run_length,
   output logic               rsp_image_done,
   output logic [1:0]         rsp_status,

   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam longint unsigned SIZE_MAX_VAL = (64'd1 << SIZE_W) - 64'd1;
   localparam logic [SIZE_W-1:0] SIZE_CAP =
      (MAX_OUTPUT_SIZE > SIZE_MAX_VAL) ? SIZE_W'(SIZE_MAX_VAL) : SIZE_W'(MAX_OUTPUT_SIZE);

   // configuration
   logic [SIZE_W-1:0] output_size_ff;
   logic [7:0]        band_count_ff;
   logic              csr_write;
   logic              csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      case (csr_index)
         REG_OUTPUT_SIZE: prdata = 32'(output_size_ff);
         REG_BAND_COUNT:  prdata = 32'(band_count_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_size_ff <= '0;
         band_count_ff  <= 8'd1;
      end else if (csr_write) begin
         case (csr_index)
            REG_OUTPUT_SIZE: output_size_ff <= pwdata[SIZE_W-1:0];
            REG_BAND_COUNT:  band_count_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   logic [7:0]        bands;
   logic [SIZE_W-1:0] size_sat;

   assign bands    = (band_count_ff == 8'd0) ? 8'd1 : band_count_ff;
   assign size_sat = (output_size_ff > SIZE_CAP) ? SIZE_CAP : output_size_ff;

   // (size - 1 - band index) / bands, one quotient bit per cycle
   logic              div_pend_ff;
   logic [4:0]        div_cnt_ff;
   logic [SIZE_W-1:0] quo_ff;
   logic [7:0]        rem_ff;
   logic              beyond_ff;
   logic [SIZE_W-1:0] size_left;
   logic [8:0]        rem_shift;
   logic              rem_ge;
   logic              div_busy;

   assign div_busy  = div_pend_ff || (div_cnt_ff != 5'd0);
   assign rem_shift = {rem_ff, quo_ff[SIZE_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, bands});

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       advance;
   logic       rsp_valid_ff;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !div_busy && (!in_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_stream_end;
      end
   end

   // decode state
   phase_type         phase_ff, phase_in;
   logic [7:0]        band_index_ff, band_index_in;
   logic [SIZE_W-1:0] wp_ff, wp_in;
   logic [SIZE_W-1:0] room_ff, room_in;
   logic [7:0]        prev_ff, prev_in;
   logic [6:0]        count_high_ff, count_high_in;
   logic              finished_ff, finished_in;
   logic              failed_ff, failed_in;

   logic               res_have;
   logic [SIZE_W-1:0]  res_index;
   logic [7:0]         res_value;
   logic [LEN_W-1:0]   res_len;
   status_type         res_status;
   logic               res_valid;

   logic [SIZE_W-1:0] room_start;
   logic [SIZE_W-1:0] room_dec;
   logic [SIZE_W-1:0] wp_step;
   logic [LEN_W-1:0]  run_n;
   logic [LEN_W-1:0]  run_len;
   logic [SIZE_W-1:0] room_after;
   logic [23:0]       run_span;
   logic              is_run;
   logic              band_end;

   assign room_start = beyond_ff ? '0 : quo_ff + SIZE_W'(1);
   assign room_dec   = room_ff - SIZE_W'(1);
   assign wp_step    = wp_ff + SIZE_W'(bands);
   assign run_n      = (phase_ff == PH_COUNT2) ?
                       LEN_W'({count_high_ff, in_byte_ff}) + LONG_COUNT_BIAS :
                       LEN_W'(in_byte_ff);
   assign run_len    = (SIZE_W'(run_n) < room_ff) ? run_n : room_ff[LEN_W-1:0];
   assign room_after = room_ff - SIZE_W'(run_len);
   assign run_span   = 24'(run_len) * 24'(bands);

   always_comb begin
      phase_in      = phase_ff;
      band_index_in = band_index_ff;
      wp_in         = wp_ff;
      room_in       = room_ff;
      prev_in       = prev_ff;
      count_high_in = count_high_ff;
      finished_in   = finished_ff;
      failed_in     = failed_ff;
      res_have      = 1'b0;
      res_index     = '0;
      res_value     = '0;
      res_len       = '0;
      res_status    = ST_OK;
      is_run        = 1'b0;
      band_end      = 1'b0;

      case (phase_ff)
         PH_BAND_START: begin
            wp_in = SIZE_W'(band_index_ff);
            if (room_start == '0) begin
               failed_in  = 1'b1;
               res_status = ST_BEYOND;
            end else begin
               res_have  = 1'b1;
               res_index = SIZE_W'(band_index_ff);
               res_value = in_byte_ff;
               res_len   = LEN_W'(1);
               prev_in   = in_byte_ff;
               wp_in     = SIZE_W'(band_index_ff) + SIZE_W'(bands);
               room_in   = room_start - SIZE_W'(1);
               if (room_start == SIZE_W'(1)) begin
                  band_end = 1'b1;
               end else begin
                  phase_in = PH_LITERAL;
               end
            end
         end
         PH_LITERAL: begin
            res_have  = 1'b1;
            res_index = wp_ff;
            res_value = in_byte_ff;
            res_len   = LEN_W'(1);
            wp_in     = wp_step;
            room_in   = room_dec;
            if (in_byte_ff == prev_ff) begin
               phase_in = PH_COUNT1;
            end else begin
               prev_in = in_byte_ff;
               if (room_dec == '0) begin
                  band_end = 1'b1;
               end
            end
         end
         PH_COUNT1: begin
            if (in_byte_ff < LONG_COUNT_BIT) begin
               is_run = 1'b1;
            end else begin
               count_high_in = in_byte_ff[6:0];
               phase_in      = PH_COUNT2;
            end
         end
         PH_COUNT2: begin
            is_run = 1'b1;
         end
         PH_AFTER_RUN: begin
            res_have  = 1'b1;
            res_index = wp_ff;
            res_value = in_byte_ff;
            res_len   = LEN_W'(1);
            wp_in     = wp_step;
            room_in   = room_dec;
            prev_in   = in_byte_ff;
            if (room_dec == '0) begin
               band_end = 1'b1;
            end else begin
               phase_in = PH_LITERAL;
            end
         end
         default: ;
      endcase

      if (is_run) begin
         if (run_len != '0) begin
            res_have  = 1'b1;
            res_index = wp_ff;
            res_value = prev_ff;
            res_len   = run_len;
         end
         wp_in   = SIZE_W'(wp_ff + SIZE_W'(run_span));
         room_in = room_after;
         if (room_after == '0) begin
            band_end = 1'b1;
         end else begin
            phase_in = PH_AFTER_RUN;
         end
      end

      if (band_end) begin
         band_index_in = band_index_ff + 8'd1;
         if ((band_index_ff + 8'd1) >= bands) begin
            finished_in = 1'b1;
         end else begin
            phase_in = PH_BAND_START;
         end
      end

      if (!failed_in && !finished_in && in_end_ff) begin
         failed_in  = 1'b1;
         res_status = ST_EARLY_END;
      end

      res_valid = res_have || (res_status != ST_OK) || finished_in;
   end

   logic active;

   assign active = advance && !finished_ff && !failed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_BAND_START;
         band_index_ff <= '0;
         wp_ff         <= '0;
         room_ff       <= '0;
         prev_ff       <= '0;
         count_high_ff <= '0;
         finished_ff   <= 1'b0;
         failed_ff     <= 1'b0;
      end else if (active) begin
         phase_ff      <= phase_in;
         band_index_ff <= band_index_in;
         wp_ff         <= wp_in;
         room_ff       <= room_in;
         prev_ff       <= prev_in;
         count_high_ff <= count_high_in;
         finished_ff   <= finished_in;
         failed_ff     <= failed_in;
      end
   end

   // quotient and remainder track the current band; one position less per band
   assign size_left = size_sat - SIZE_W'(band_index_ff) - SIZE_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_pend_ff <= 1'b0;
         div_cnt_ff  <= '0;
         quo_ff      <= '0;
         rem_ff      <= '0;
         beyond_ff   <= 1'b1;
      end else begin
         div_pend_ff <= csr_write;
         if (div_pend_ff) begin
            div_cnt_ff <= 5'(DIV_STEPS);
            beyond_ff  <= (size_sat <= SIZE_W'(band_index_ff));
            quo_ff     <= (size_sat <= SIZE_W'(band_index_ff)) ? '0 : size_left;
            rem_ff     <= '0;
         end else if (div_cnt_ff != 5'd0) begin
            div_cnt_ff <= div_cnt_ff - 5'd1;
            quo_ff     <= {quo_ff[SIZE_W-2:0], rem_ge};
            rem_ff     <= rem_ge ? 8'(rem_shift - {1'b0, bands}) : rem_shift[7:0];
         end else if (active && band_end) begin
            if (rem_ff != 8'd0) begin
               rem_ff <= rem_ff - 8'd1;
            end else if (quo_ff != '0) begin
               quo_ff <= quo_ff - SIZE_W'(1);
               rem_ff <= bands - 8'd1;
            end else begin
               beyond_ff <= 1'b1;
            end
         end
      end
   end

   // result register
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [7:0]         rsp_value_ff;
   logic [LEN_W-1:0]   rsp_len_ff;
   logic               rsp_done_ff;
   status_type         rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (active && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (active && res_valid) begin
         rsp_index_ff  <= res_index[INDEX_W-1:0];
         rsp_value_ff  <= res_value;
         rsp_len_ff    <= res_len;
         rsp_done_ff   <= finished_in;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_index  = rsp_index_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_run_length = rsp_len_ff;
   assign rsp_image_done = rsp_done_ff;
   assign rsp_status     = rsp_status_ff;

   `BPRD_ASSERT(a_beyond_no_run, clock, reset,
      rsp_valid && (rsp_status == ST_BEYOND) |-> rsp_run_length == '0)
   `BPRD_ASSERT(a_done_is_ok, clock, reset,
      rsp_valid && rsp_image_done |-> rsp_status == ST_OK)
   `BPRD_ASSERT(a_quiet_after_stop, clock, reset,
      (finished_ff || failed_ff) && !rsp_valid_ff |=> !rsp_valid_ff)
   `BPRD_ASSERT_NEVER(a_room_in_band, clock, reset,
      !finished_ff && !failed_ff && room_ff == '0 &&
      (phase_ff == PH_LITERAL || phase_ff == PH_AFTER_RUN))

endmodule
